@@ src/psr_pkg.sv @@
// shared types and constants for the polyline step resampler
`default_nettype none
package psr_pkg;
	localparam int MAX_STEPS = 63;
	localparam int CW = 32;
	localparam int AW = 48;
	localparam logic [30:0] STEP_RESET = 31'd65536;
	localparam logic [AW-1:0] ARC_MAX = {AW{1'b1}};

	typedef struct packed {
		logic load;      // capture waypoint and diffs
		logic start_sq;  // square and sum
		logic start_div;
		logic init_emit; // set up sample counter
		logic next_pt;   // compute the next sample
		logic commit;    // update prev and length sum
		logic restart;   // store as path start
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic pt_done;
		logic zero_n;
		logic last_j;
	} sts_t;
endpackage
`default_nettype wire

@@ src/polyline_step_resampler_core.sv @@
// top level of the polyline step resampler
// usage:
//  s_axis carries one waypoint per request: tdata = way_x, way_y, way_z
//  (lowest first), tuser = path_start, tlast = path_final. m_axis carries
//  samples: tdata = pt_x, pt_y, pt_z, arc_length; tuser = path_done;
//  tlast = run_last. cfg_valid/cfg_ready write step_length while idle.
// sequence: a start waypoint only restarts the path. a segment is squared,
//  then rooted (two radicand bits per cycle), then count-divided; each
//  sample takes four 40-step quotients in the shared serial divider.
//  the block takes one waypoint at a time.
// reset clears the previous point, the arc sum and the path state and
//  loads step_length with 1.0. a stalled receiver holds the output
//  register and the sequencer waits; nothing is dropped.
`default_nettype none
module polyline_step_resampler_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // way_x, way_y, way_z
	input  wire logic s_axis_tuser,         // path_start
	input  wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [143:0] m_axis_tdata,      // pt_x, pt_y, pt_z, arc_length
	output logic m_axis_tlast,
	output logic m_axis_tuser,              // path_done
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [30:0] cfg_data
);
	import psr_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic busy, out_set, out_end, have_prev, fin, emits, in_fire, out_free;
	logic [30:0] step_q;
	logic [31:0] ox, oy, oz, cx, cy, cz;
	logic [47:0] oarc, earc;
	logic ov_q, last_q, done_q;
	logic [143:0] od_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !ov_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= STEP_RESET;
		else if (cfg_valid) step_q <= cfg_data;
	end

	psr_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.restart(s_axis_tuser || !have_prev),
		.out_free, .fin, .sts, .cmd, .busy, .out_set, .out_end
	);

	psr_dp u_dp (
		.clk, .arst_n, .cmd,
		.way_x(s_axis_tdata[31:0]), .way_y(s_axis_tdata[63:32]),
		.way_z(s_axis_tdata[95:64]), .path_final(s_axis_tlast),
		.step_q, .sts, .have_prev, .fin,
		.o_x(ox), .o_y(oy), .o_z(oz), .o_arc(oarc),
		.c_x(cx), .c_y(cy), .c_z(cz), .end_arc(earc), .emits
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (out_set || out_end) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_set) begin
			od_q <= {oarc, oz, oy, ox};
			last_q <= sts.last_j && !fin;
			done_q <= 1'b0;
		end else if (out_end) begin
			od_q <= {earc, cz, cy, cx};
			last_q <= 1'b1;
			done_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tlast = last_q;
	assign m_axis_tuser = done_q;

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("input taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !m_axis_tready) |=> (ov_q && $stable(od_q)))
		else $error("output lost on stall");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_set && out_end)) else $error("two output loads");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_set |-> emits) else $error("sample with zero count");
endmodule
`default_nettype wire

@@ src/psr_ctrl.sv @@
// controller state machine of the polyline step resampler
`default_nettype none
module psr_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic restart,
	input  wire logic out_free,
	input  wire logic fin,
	input  wire psr_pkg::sts_t sts,
	output psr_pkg::cmd_t cmd,
	output logic busy,
	output logic out_set,
	output logic out_end
);
	import psr_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_SQRT = 3'd2, S_DIV = 3'd3,
		S_PT = 3'd4, S_OUT = 3'd5, S_END = 3'd6;
	logic [2:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		out_set = 1'b0;
		out_end = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_fire) begin
				if (restart) cmd.restart = 1'b1;
				else begin
					cmd.load = 1'b1;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.start_sq = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: if (sts.sqrt_done) begin
				cmd.start_div = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: if (sts.div_done) begin
				cmd.init_emit = 1'b1;
				state_d = S_PT;
			end
			S_PT: begin
				if (sts.zero_n) state_d = S_END;
				else if (sts.pt_done) state_d = S_OUT;
				else cmd.next_pt = 1'b1;
			end
			S_OUT: if (out_free) begin
				out_set = 1'b1;
				if (sts.last_j) state_d = S_END;
				else begin
					cmd.next_pt = 1'b1;
					state_d = S_PT;
				end
			end
			S_END: if (!fin) begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end else if (out_free) begin
				out_end = 1'b1;
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

@@ src/psr_dp.sv @@
// datapath: squares, root, count divide, interpolation
`default_nettype none
module psr_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire psr_pkg::cmd_t cmd,
	input  wire logic [31:0] way_x,
	input  wire logic [31:0] way_y,
	input  wire logic [31:0] way_z,
	input  wire logic path_final,
	input  wire logic [30:0] step_q,
	output psr_pkg::sts_t sts,
	output logic have_prev,
	output logic fin,
	output logic [31:0] o_x,
	output logic [31:0] o_y,
	output logic [31:0] o_z,
	output logic [47:0] o_arc,
	output logic [31:0] c_x,
	output logic [31:0] c_y,
	output logic [31:0] c_z,
	output logic [47:0] end_arc,
	output logic emits
);
	import psr_pkg::*;
	logic [31:0] px_q, py_q, pz_q, cx_q, cy_q, cz_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic hp_q, fin_q;
	logic [47:0] lsum_q;
	logic [65:0] sq_q;
	logic [1:0] sqi_q;
	// root
	logic [33:0] root_q;
	logic [35:0] rem_q;
	logic [5:0] rcnt_q;
	logic sqrt_run_q, sqrt_done_q;
	// count divide: n = ceil(d/step), long division on d+step-1
	logic [34:0] dnum_q;
	logic [34:0] quo_q;
	logic [31:0] drem_q;
	logic [5:0] dcnt_q;
	logic div_run_q, div_done_q;
	logic [5:0] n_q, j_q;
	// per-sample division: four numerators, shared serial divider
	logic [1:0] ax_q;
	logic [6:0] pc_q;
	logic [39:0] num_q;
	logic [39:0] pq_q;
	logic [7:0] prm_q;
	logic pt_run_q, pt_done_q;
	logic [31:0] ox_q, oy_q, oz_q;
	logic [47:0] oarc_q;
	logic [6:0] den;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	assign den = {n_q, 1'b0};

	logic [32:0] sqm;
	always_comb begin
		unique case (sqi_q)
			2'd0: sqm = mag33(dx_q);
			2'd1: sqm = mag33(dy_q);
			default: sqm = mag33(dz_q);
		endcase
	end
	logic [65:0] sqp;
	assign sqp = 66'(sqm) * 66'(sqm);

	logic [35:0] trial;
	logic [35:0] remsh;
	assign remsh = {rem_q[33:0], sq_q[65:64]};
	assign trial = {root_q[33:0], 2'b01};

	logic [32:0] dsh;
	assign dsh = {drem_q, dnum_q[34]};
	logic [7:0] psh;
	assign psh = {prm_q[6:0], num_q[39]};

	logic signed [33:0] offv;
	logic [39:0] qv;
	logic [32:0] base;
	assign qv = {pq_q[38:0], (psh >= {1'b0, den})};
	always_comb begin
		unique case (ax_q)
			2'd0: base = {px_q[31], px_q};
			2'd1: base = {py_q[31], py_q};
			default: base = {pz_q[31], pz_q};
		endcase
	end
	logic neg;
	always_comb begin
		unique case (ax_q)
			2'd0: neg = dx_q[32];
			2'd1: neg = dy_q[32];
			default: neg = dz_q[32];
		endcase
	end
	assign offv = neg ? -34'(qv[33:0]) : 34'(qv[33:0]);
	logic [33:0] ptv;
	assign ptv = 34'($signed(base)) + offv;
	logic [48:0] arcs;
	assign arcs = {1'b0, lsum_q} + 49'(qv);
	logic [48:0] lnew;
	assign lnew = {1'b0, lsum_q} + 49'(root_q);

	logic [32:0] nx_mg;
	always_comb begin
		unique case (ax_q)
			2'd0: nx_mg = mag33(dy_q);
			2'd1: nx_mg = mag33(dz_q);
			default: nx_mg = root_q[32:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= 1'b0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			lsum_q <= '0;
			sqrt_run_q <= 1'b0; sqrt_done_q <= 1'b0;
			div_run_q <= 1'b0; div_done_q <= 1'b0;
			pt_run_q <= 1'b0; pt_done_q <= 1'b0;
		end else begin
			sqrt_done_q <= 1'b0;
			div_done_q <= 1'b0;
			if (cmd.restart) begin
				px_q <= way_x; py_q <= way_y; pz_q <= way_z;
				lsum_q <= '0;
				hp_q <= !path_final;
			end
			if (cmd.load) begin
				cx_q <= way_x; cy_q <= way_y; cz_q <= way_z;
				fin_q <= path_final;
				dx_q <= $signed({way_x[31], way_x}) - $signed({px_q[31], px_q});
				dy_q <= $signed({way_y[31], way_y}) - $signed({py_q[31], py_q});
				dz_q <= $signed({way_z[31], way_z}) - $signed({pz_q[31], pz_q});
				sq_q <= '0;
				sqi_q <= 2'd0;
			end
			if (cmd.start_sq || (sqi_q != 2'd3 && sqi_q != 2'd0)) begin
				sq_q <= sq_q + sqp;
				sqi_q <= (sqi_q == 2'd2) ? 2'd3 : sqi_q + 2'd1;
				if (sqi_q == 2'd2) begin
					// sum of squares is below 2^66, so 33 bit pairs
					sqrt_run_q <= 1'b1;
					root_q <= '0; rem_q <= '0; rcnt_q <= 6'd33;
				end
			end
			if (sqrt_run_q) begin
				if (remsh >= trial) begin
					rem_q <= remsh - trial;
					root_q <= {root_q[32:0], 1'b1};
				end else begin
					rem_q <= remsh;
					root_q <= {root_q[32:0], 1'b0};
				end
				sq_q <= {sq_q[63:0], 2'b00};
				rcnt_q <= rcnt_q - 6'd1;
				if (rcnt_q == 6'd1) begin
					sqrt_run_q <= 1'b0;
					sqrt_done_q <= 1'b1;
				end
			end
			if (cmd.start_div) begin
				dnum_q <= 35'(root_q) + 35'((step_q == '0) ? 31'd1 : step_q) - 35'd1;
				drem_q <= '0; quo_q <= '0; dcnt_q <= 6'd35;
				div_run_q <= 1'b1;
			end
			if (div_run_q) begin
				if (dsh >= 33'((step_q == '0) ? 31'd1 : step_q)) begin
					drem_q <= 32'(dsh - 33'((step_q == '0) ? 31'd1 : step_q));
					quo_q <= {quo_q[33:0], 1'b1};
				end else begin
					drem_q <= dsh[31:0];
					quo_q <= {quo_q[33:0], 1'b0};
				end
				dnum_q <= {dnum_q[33:0], 1'b0};
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) begin
					div_run_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
			if (cmd.init_emit) begin
				n_q <= (quo_q > 35'(MAX_STEPS)) ? 6'(MAX_STEPS) : quo_q[5:0];
				j_q <= '0;
				pt_done_q <= 1'b0;
				pt_run_q <= 1'b0;
			end
			if (cmd.next_pt && !pt_run_q) begin
				// numerator 2*|diff|*j + n
				ax_q <= 2'd0;
				num_q <= 40'(({mag33(dx_q), 1'b0} * 40'(j_q)) + 40'(n_q));
				prm_q <= '0; pq_q <= '0; pc_q <= 7'd40;
				pt_run_q <= 1'b1;
				pt_done_q <= 1'b0;
			end
			if (pt_run_q) begin
				prm_q <= (psh >= {1'b0, den}) ? 8'(psh - {1'b0, den}) : psh;
				pq_q <= qv;
				num_q <= {num_q[38:0], 1'b0};
				pc_q <= pc_q - 7'd1;
				if (pc_q == 7'd1) begin
					unique case (ax_q)
						2'd0: ox_q <= ptv[31:0];
						2'd1: oy_q <= ptv[31:0];
						2'd2: oz_q <= ptv[31:0];
						default: oarc_q <= arcs[48] ? ARC_MAX : arcs[47:0];
					endcase
					if (ax_q == 2'd3) begin
						pt_run_q <= 1'b0;
						pt_done_q <= 1'b1;
						j_q <= j_q + 6'd1;
					end else begin
						ax_q <= ax_q + 2'd1;
						prm_q <= '0; pq_q <= '0; pc_q <= 7'd40;
						num_q <= 40'(({nx_mg, 1'b0} * 40'(j_q)) + 40'(n_q));
					end
				end
			end
			if (cmd.commit) begin
				px_q <= cx_q; py_q <= cy_q; pz_q <= cz_q;
				lsum_q <= lnew[48] ? ARC_MAX : lnew[47:0];
				hp_q <= !fin_q;
			end
		end
	end

	assign sts.sqrt_done = sqrt_done_q;
	assign sts.div_done = div_done_q;
	assign sts.pt_done = pt_done_q && !pt_run_q;
	assign sts.zero_n = (n_q == '0);
	assign sts.last_j = (j_q == n_q);
	assign have_prev = hp_q;
	assign fin = fin_q;
	assign o_x = ox_q; assign o_y = oy_q; assign o_z = oz_q;
	assign o_arc = oarc_q;
	assign c_x = cx_q; assign c_y = cy_q; assign c_z = cz_q;
	assign end_arc = lnew[48] ? ARC_MAX : lnew[47:0];
	assign emits = (n_q != '0);
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the polyline step resampler core
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import psr_pkg::*;

	localparam int IDLE_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 700;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [AW-1:0] arc;
		logic last;
		logic done;
	} sample_t;

	class sample_board;
		sample_t pending[$];
		bit [30:0] step_len;
		bit signed [CW-1:0] px, py, pz;
		bit open_path;
		bit [63:0] len_sum;
		int mismatches;

		function new();
			step_len = STEP_RESET;
			open_path = 0;
			len_sum = 0;
			px = 0;
			py = 0;
			pz = 0;
			mismatches = 0;
		endfunction

		// floor square root of a sum of three squares
		function bit [63:0] isqrt(bit [67:0] v);
			bit [67:0] rem, root, trial;
			rem = 0;
			root = 0;
			for (int p = 33; p >= 0; p--) begin
				rem = (rem << 2) | v[2*p +: 2];
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			return root[63:0];
		endfunction

		// rounded to nearest, ties away from zero
		function bit [CW-1:0] lerp(bit signed [CW-1:0] p, longint diff, longint j,
				longint n);
			longint mg, off;
			mg = diff < 0 ? -diff : diff;
			off = (2 * mg * j + n) / (2 * n);
			if (diff < 0)
				off = -off;
			return CW'(longint'(p) + off);
		endfunction

		function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
			bit [63:0] s;
			s = a + b;
			return s > ARC_MAX ? 64'(ARC_MAX) : s;
		endfunction

		function void note_waypoint(bit signed [CW-1:0] cx, cy, cz, bit st, bit fin);
			longint dx, dy, dz;
			bit [67:0] mx, my, mz;
			bit [67:0] sq;
			bit [63:0] d, stp, n;
			sample_t s;
			int first;
			if (st || !open_path) begin
				px = cx;
				py = cy;
				pz = cz;
				len_sum = 0;
				open_path = !fin;
				return;
			end
			first = pending.size();
			dx = longint'(cx) - longint'(px);
			dy = longint'(cy) - longint'(py);
			dz = longint'(cz) - longint'(pz);
			mx = 68'(dx < 0 ? -dx : dx);
			my = 68'(dy < 0 ? -dy : dy);
			mz = 68'(dz < 0 ? -dz : dz);
			sq = mx * mx + my * my + mz * mz;
			d = isqrt(sq);
			stp = step_len == 0 ? 1 : step_len;
			n = (d + stp - 1) / stp;
			if (n > MAX_STEPS)
				n = MAX_STEPS;
			for (longint j = 0; j < n; j++) begin
				s.x = lerp(px, dx, j, n);
				s.y = lerp(py, dy, j, n);
				s.z = lerp(pz, dz, j, n);
				s.arc = AW'(sat_add(len_sum, (2 * d * j + n) / (2 * n)));
				s.last = 0;
				s.done = 0;
				pending.push_back(s);
			end
			len_sum = sat_add(len_sum, d);
			if (fin) begin
				s.x = cx;
				s.y = cy;
				s.z = cz;
				s.arc = AW'(len_sum);
				s.last = 0;
				s.done = 1;
				pending.push_back(s);
			end
			if (pending.size() > first)
				pending[pending.size()-1].last = 1;
			px = cx;
			py = cy;
			pz = cz;
			open_path = !fin;
		endfunction

		function void check_sample(sample_t got);
			sample_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
					got.arc !== want.arc || got.last !== want.last ||
					got.done !== want.done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample mismatch: x %h/%h y %h/%h z %h/%h arc %h/%h last %b/%b done %b/%b (exp/got)",
						want.x, got.x, want.y, got.y, want.z, got.z, want.arc, got.arc,
						want.last, got.last, want.done, got.done);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [95:0] s_axis_tdata;    // way_x, way_y, way_z
	logic s_axis_tuser;           // path_start
	logic s_axis_tlast;
	logic m_axis_tvalid, m_axis_tready;
	logic [143:0] m_axis_tdata;   // pt_x, pt_y, pt_z, arc_length
	logic m_axis_tlast;
	logic m_axis_tuser;           // path_done
	logic cfg_valid, cfg_ready;
	logic [30:0] cfg_data;

	sample_board board = new();
	bit calm = 0;
	bit hold_req = 0;
	int idle_cycles = 0;
	bit signed [CW-1:0] wx, wy, wz;

	always #4 clk = ~clk;

	polyline_step_resampler_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_sample({m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tdata[143:96], m_axis_tlast, m_axis_tuser});
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("polyline_step_resampler_core test failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		m_axis_tready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	task automatic send_waypoint(bit signed [CW-1:0] x, y, z, bit st, bit fin);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x};
		s_axis_tuser <= st;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		board.note_waypoint(x, y, z, st, fin);
		wx = x;
		wy = y;
		wz = z;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(bit [30:0] v);
		wait_drained();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.step_len = v;
	endtask

	function automatic bit signed [CW-1:0] walk(bit signed [CW-1:0] p, int unsigned reach);
		longint v;
		if (reach == 0)
			return $urandom;
		v = longint'(p) + longint'($urandom_range(0, 2 * reach)) - longint'(reach);
		if (v > 64'sh7fffffff)
			v = 64'sh7fffffff;
		if (v < -64'sh80000000)
			v = -64'sh80000000;
		return CW'(v);
	endfunction

	// mostly well-formed paths, some noise waypoints with random flags
	task automatic random_paths(int items, int unsigned reach);
		int sent, len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_waypoint(walk(wx, reach), walk(wy, reach), walk(wz, reach),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				len = $urandom_range(2, 7);
				send_waypoint($urandom, $urandom, $urandom, 1, 0);
				for (int k = 1; k < len; k++) begin
					if ($urandom_range(0, 15) == 0)
						send_waypoint(wx, wy, wz, 0, k == len - 1);
					else
						send_waypoint(walk(wx, reach), walk(wy, reach), walk(wz, reach), 0,
							k == len - 1);
				end
				sent += len;
			end
		end
	endtask

	initial begin
		arst_n <= 0;
		s_axis_tvalid <= 0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 0;
		s_axis_tlast <= 0;
		cfg_valid <= 0;
		cfg_data <= '0;
		wx = 0;
		wy = 0;
		wz = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset step of 1.0
		send_waypoint(0, 0, 0, 0, 0);                      // no open path: becomes start
		send_waypoint(32'sh10000, 0, 0, 0, 0);
		send_waypoint(32'sh10000, 0, 0, 0, 0);             // zero-length segment
		send_waypoint(32'sh10000, 32'sh28000, -32'sh18000, 0, 0);
		send_waypoint(32'sh10000, 32'sh28000, -32'sh18000, 0, 1); // zero length on final
		send_waypoint(5, 6, 7, 1, 1);                      // single-waypoint path
		send_waypoint(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0);
		send_waypoint(-32'sh80000000, -32'sh80000000, -32'sh80000000, 0, 0); // saturated count
		send_waypoint(-32'sh80000000, 32'sh7fffffff, 0, 1, 0); // abandons the open path
		send_waypoint(-32'sh7ffd0000, 32'sh7ffc0000, 32'sh30000, 0, 1);

		// long output hold while waypoints keep coming
		hold_req = 1;
		send_waypoint(0, 0, 0, 1, 0);
		for (int k = 1; k <= 5; k++)
			send_waypoint(k * 32'sh30000, -k * 32'sh20000, k * 32'sh8000, 0, k == 5);

		write_step(31'd1);
		send_waypoint(0, 0, 0, 1, 0);
		send_waypoint(3, -3, 0, 0, 0);                     // rounding ties
		send_waypoint(-2, 4, 1, 0, 0);
		send_waypoint(-2, 4, 1, 0, 0);
		send_waypoint(100, -100, 60, 0, 1);                // count saturates
		random_paths(10, 12);

		write_step(31'h7fffffff);
		random_paths(150, 0);
		wait_drained();                                    // sender pause until empty

		write_step(31'($urandom_range(1 << 14, 1 << 18)));
		random_paths(140, 4 * board.step_len);
		write_step(31'($urandom_range(1 << 14, 1 << 18)));
		calm = 1;
		random_paths(70, 4 * board.step_len);

		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("polyline_step_resampler_core test passed");
		else
			$display("polyline_step_resampler_core test failed");
		$finish;
	end
endmodule
`default_nettype wire
